FILE: hdl/cfb_pkg.sv
`timescale 1ns / 1ps

package cfb_pkg;

	localparam int DEF_MAX_PAYLOAD = 8;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 4;
	localparam int IDX_W = 3;
	localparam int SEQ_W = 7;
	localparam int PAY_W = 64;

	localparam logic [BYTE_W-1:0] FRAME_START = 8'hAA;
	localparam logic [BYTE_W-1:0] FRAME_END = 8'h55;
	localparam logic [SEQ_W-1:0] SEQ_TOP = 7'd127;
	localparam logic [SEQ_W-1:0] SEQ_FIRST = 7'd1;
	localparam logic [BYTE_W-1:0] LEN_BASE = 8'd2;

	// byte source selected for the next frame byte
	localparam logic [2:0] SEL_START = 3'd0;
	localparam logic [2:0] SEL_LEN = 3'd1;
	localparam logic [2:0] SEL_SEQ = 3'd2;
	localparam logic [2:0] SEL_CMD = 3'd3;
	localparam logic [2:0] SEL_PAY = 3'd4;
	localparam logic [2:0] SEL_SUM = 3'd5;
	localparam logic [2:0] SEL_END = 3'd6;

	typedef struct packed {
		logic       accept;
		logic       emit;
		logic [2:0] sel;
		logic       acc_en;
		logic       last;
	} cfb_ctrl_t;

endpackage

FILE: hdl/cfb_csum.sv
`timescale 1ns / 1ps

module cfb_csum
	import cfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              en,
	input  logic [BYTE_W-1:0] din,
	output logic [BYTE_W-1:0] sum
);

	logic [BYTE_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clr) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_q ^ din;
		end
	end

	assign sum = sum_q;

endmodule

FILE: hdl/cfb_ctrl.sv
`timescale 1ns / 1ps

module cfb_ctrl
	import cfb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CNT_W-1:0] count,
	input  logic             out_free,
	output cfb_ctrl_t        ctrl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_LEN = 3'd2;
	localparam logic [2:0] ST_SEQ = 3'd3;
	localparam logic [2:0] ST_CMD = 3'd4;
	localparam logic [2:0] ST_PAY = 3'd5;
	localparam logic [2:0] ST_SUM = 3'd6;
	localparam logic [2:0] ST_END = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             pay_done;
	logic             emit;

	assign in_ready = (state_q == ST_IDLE);
	assign emit = (state_q != ST_IDLE) && out_free;
	assign pay_done = (({1'b0, idx_q} + 1'b1) == cnt_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_START;
			ST_START: state_d = ST_LEN;
			ST_LEN:   state_d = ST_SEQ;
			ST_SEQ:   state_d = ST_CMD;
			ST_CMD:   state_d = (cnt_q == '0) ? ST_SUM : ST_PAY;
			ST_PAY:   if (pay_done) state_d = ST_SUM;
			ST_SUM:   state_d = ST_END;
			ST_END:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (in_ready) begin
			if (in_valid) begin
				state_q <= state_d;
				cnt_q <= count;
				idx_q <= '0;
			end
		end else if (emit) begin
			state_q <= state_d;
			if (state_q == ST_PAY) idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		ctrl.accept = in_ready && in_valid;
		ctrl.emit = emit;
		ctrl.sel = SEL_START;
		unique case (state_q)
			ST_IDLE:  ctrl.sel = SEL_START;
			ST_START: ctrl.sel = SEL_START;
			ST_LEN:   ctrl.sel = SEL_LEN;
			ST_SEQ:   ctrl.sel = SEL_SEQ;
			ST_CMD:   ctrl.sel = SEL_CMD;
			ST_PAY:   ctrl.sel = SEL_PAY;
			ST_SUM:   ctrl.sel = SEL_SUM;
			ST_END:   ctrl.sel = SEL_END;
			default:  ctrl.sel = SEL_START;
		endcase
		ctrl.acc_en = emit && (state_q == ST_LEN || state_q == ST_SEQ
			|| state_q == ST_CMD || state_q == ST_PAY);
		ctrl.last = (state_q == ST_END);
	end

endmodule

FILE: hdl/command_frame_builder.sv
`timescale 1ns / 1ps

// Builds one command frame per request: 0xAA, length (2 + payload count), sequence
// number, command, payload bytes, XOR checksum of length through last payload byte,
// 0x55 (tlast). Payload counts above MAX_PAYLOAD are clamped. The sequence number
// starts at 1 and wraps from 127 to 1. A request is taken only while the block is
// idle; the byte sequencer then sends one byte per cycle through the output register
// unless m_tready stalls it, and its single XOR accumulator builds the checksum.
module command_frame_builder
	import cfb_pkg::*;
#(
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // command_code[7:0], payload_count[11:8], payload_bytes[75:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // frame_byte[7:0]
	output logic        m_tlast
);

	logic [BYTE_W-1:0] cmd_in;
	logic [CNT_W-1:0]  count_in;
	logic [PAY_W-1:0]  pay_in;
	logic [CNT_W-1:0]  count_sat;

	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] len_q;
	logic [PAY_W-1:0]  pay_q;
	logic [SEQ_W-1:0]  seq_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_free;

	cfb_ctrl_t         ctrl;
	logic [BYTE_W-1:0] byte_d;
	logic [BYTE_W-1:0] csum;

	assign cmd_in = s_tdata[7:0];
	assign count_in = s_tdata[11:8];
	assign pay_in = s_tdata[75:12];
	assign count_sat = (count_in > CNT_W'(MAX_PAYLOAD)) ? CNT_W'(MAX_PAYLOAD) : count_in;

	assign out_free = !out_valid_q || m_tready;

	cfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.count    (count_sat),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	cfb_csum u_csum (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (ctrl.accept),
		.en     (ctrl.acc_en),
		.din    (byte_d),
		.sum    (csum)
	);

	always_comb begin
		byte_d = FRAME_START;
		unique case (ctrl.sel)
			SEL_START: byte_d = FRAME_START;
			SEL_LEN:   byte_d = len_q;
			SEL_SEQ:   byte_d = {1'b0, seq_q};
			SEL_CMD:   byte_d = cmd_q;
			SEL_PAY:   byte_d = pay_q[BYTE_W-1:0];
			SEL_SUM:   byte_d = csum;
			SEL_END:   byte_d = FRAME_END;
			default:   byte_d = FRAME_START;
		endcase
	end

	// request holding registers; payload shifts down one byte per payload transfer
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q <= cmd_in;
			len_q <= LEN_BASE + {{(BYTE_W-CNT_W){1'b0}}, count_sat};
			pay_q <= pay_in;
		end else if (ctrl.emit && ctrl.sel == SEL_PAY) begin
			pay_q <= pay_q >> BYTE_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_FIRST;
		end else if (ctrl.emit && ctrl.last) begin
			seq_q <= (seq_q == SEQ_TOP || seq_q == '0) ? SEQ_FIRST : seq_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
			out_last_q <= ctrl.last;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) out_byte_q <= byte_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_last_q;

endmodule
